>>> hw/rtl/atp_pkg.sv
// Shared types, codes and keyword tables for the age text parser.
package atp_pkg;

  localparam int OUT_W   = 17;
  localparam int Q_DEPTH = 2;

  localparam logic [1:0] ST_UNITS   = 2'd0;
  localparam logic [1:0] ST_KEYWORD = 2'd1;
  localparam logic [1:0] ST_INVALID = 2'd2;

  localparam logic [1:0] MOD_NONE = 2'd0;
  localparam logic [1:0] MOD_LT   = 2'd1;
  localparam logic [1:0] MOD_GT   = 2'd2;

  localparam logic [1:0] KW_CHILD     = 2'd0;
  localparam logic [1:0] KW_INFANT    = 2'd1;
  localparam logic [1:0] KW_STILLBORN = 2'd2;

  localparam logic [7:0] CHILD_YEARS     = 8'd8;
  localparam logic [7:0] INFANT_YEARS    = 8'd1;
  localparam logic [7:0] STILLBORN_YEARS = 8'd0;

  typedef enum logic [2:0] {
    UNIT_NONE,
    UNIT_Y,
    UNIT_M,
    UNIT_W,
    UNIT_D
  } unit_t;

  // one byte after classification; letter is folded to upper case
  typedef struct packed {
    logic       is_end;
    logic       is_space;
    logic       is_digit;
    logic [3:0] digit;
    logic       is_lt;
    logic       is_gt;
    unit_t      unit;
    logic [7:0] letter;
  } atp_class_t;

  function automatic logic [3:0] kw_len(logic [1:0] w);
    logic [3:0] n;
    case (w)
      KW_CHILD:     n = 4'd5;
      KW_INFANT:    n = 4'd6;
      KW_STILLBORN: n = 4'd9;
      default:      n = 4'd5;
    endcase
    return n;
  endfunction

  function automatic logic [7:0] kw_char(logic [1:0] w, logic [3:0] p);
    logic [7:0] ch;
    ch = 8'h00;
    case (w)
      KW_INFANT: begin
        case (p)
          4'd0: ch = "I";
          4'd1: ch = "N";
          4'd2: ch = "F";
          4'd3: ch = "A";
          4'd4: ch = "N";
          4'd5: ch = "T";
          default: ch = 8'h00;
        endcase
      end
      KW_STILLBORN: begin
        case (p)
          4'd0: ch = "S";
          4'd1: ch = "T";
          4'd2: ch = "I";
          4'd3: ch = "L";
          4'd4: ch = "L";
          4'd5: ch = "B";
          4'd6: ch = "O";
          4'd7: ch = "R";
          4'd8: ch = "N";
          default: ch = 8'h00;
        endcase
      end
      default: begin
        case (p)
          4'd0: ch = "C";
          4'd1: ch = "H";
          4'd2: ch = "I";
          4'd3: ch = "L";
          4'd4: ch = "D";
          default: ch = 8'h00;
        endcase
      end
    endcase
    return ch;
  endfunction

endpackage

>>> hw/rtl/atp_in_if.sv
// Input byte channel of the age text parser.
interface atp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       end_of_text;

  modport source (output valid, output char_code, output end_of_text, input ready);
  modport sink   (input valid, input char_code, input end_of_text, output ready);
endinterface

>>> hw/rtl/atp_out_if.sv
// Result channel of the age text parser.
interface atp_out_if import atp_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic        [1:0]       status;
  logic        [1:0]       modifier;
  logic signed [OUT_W-1:0] years;
  logic signed [OUT_W-1:0] months;
  logic signed [OUT_W-1:0] weeks;
  logic signed [OUT_W-1:0] days;

  modport source (output valid, output status, output modifier, output years,
                  output months, output weeks, output days, input ready);
  modport sink   (input valid, input status, input modifier, input years,
                  input months, input weeks, input days, output ready);
endinterface

>>> hw/rtl/age_text_parser.sv
// Top level of the age text parser: front end, byte queue and parse back end.
//
// in_ch carries one text byte per transaction (char_code, end_of_text). A
// transaction with end_of_text set, or a zero byte, ends the text; out_ch then
// carries one result: status, modifier and the year, month, week and day
// counts, each -1 when absent. Counts saturate at 2^COUNT_WIDTH - 1.
// Throughput is one byte per cycle: the back end's state machine and its
// multiply-by-ten accumulate take one queued byte in every cycle unless an
// end byte must wait. Bytes are parsed as they leave the queue head; an end
// byte's result is loaded into the output register that drives out_ch.
// A two-entry queue between front and back absorbs stalls. When out_ch is
// stalled, plain bytes keep flowing and only an end byte waits at the queue
// head; in_ch.ready drops once the queue is full.
// Reset clears the parse state and the queue and drops out_ch.valid; the
// block is ready for a new text in the first cycle after reset.
module age_text_parser import atp_pkg::*; #(
  parameter int COUNT_WIDTH = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  atp_in_if.sink    in_ch,
  atp_out_if.source out_ch
);

  logic       push;
  atp_class_t push_data;
  logic       pop;
  logic       q_valid;
  logic       q_full;
  atp_class_t q_data;

  atp_front u_front (
    .in_ch     (in_ch),
    .q_full    (q_full),
    .push      (push),
    .push_data (push_data)
  );

  atp_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .q_valid   (q_valid),
    .q_full    (q_full),
    .q_data    (q_data)
  );

  atp_back #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .q_data  (q_data),
    .pop     (pop),
    .out_ch  (out_ch)
  );

endmodule

>>> hw/rtl/atp_front.sv
// Front end: takes input bytes and classifies them for the parser.
module atp_front import atp_pkg::*; (
  atp_in_if.sink     in_ch,
  input  logic       q_full,
  output logic       push,
  output atp_class_t push_data
);

  logic [7:0] c;
  logic [7:0] up;

  assign c  = in_ch.char_code;
  assign up = (c >= "a" && c <= "z") ? c - 8'd32 : c;

  assign in_ch.ready = !q_full;
  assign push        = in_ch.valid && !q_full;

  always_comb begin
    push_data          = '0;
    // a zero byte ends the text like an end item
    push_data.is_end   = in_ch.end_of_text || (c == 8'h00);
    push_data.is_space = (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
    push_data.is_digit = (c >= "0" && c <= "9");
    push_data.digit    = c[3:0];
    push_data.is_lt    = (c == "<");
    push_data.is_gt    = (c == ">");
    push_data.letter   = up;
    case (up)
      "Y":     push_data.unit = UNIT_Y;
      "M":     push_data.unit = UNIT_M;
      "W":     push_data.unit = UNIT_W;
      "D":     push_data.unit = UNIT_D;
      default: push_data.unit = UNIT_NONE;
    endcase
  end

endmodule

>>> hw/rtl/atp_queue.sv
// Short queue of classified bytes between front and back.
module atp_queue import atp_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  atp_class_t push_data,
  input  logic       pop,
  output logic       q_valid,
  output logic       q_full,
  output atp_class_t q_data
);

  localparam int PW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int CW = $clog2(Q_DEPTH + 1);

  atp_class_t      entry_r [Q_DEPTH];
  logic [PW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   count_r, count_nxt;

  assign q_valid = (count_r != '0);
  assign q_full  = (count_r == CW'(Q_DEPTH));
  assign q_data  = entry_r[rd_ptr_r];

  function automatic logic [PW-1:0] ptr_inc(logic [PW-1:0] p);
    return (p == PW'(Q_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_comb begin
    wr_ptr_nxt = push ? ptr_inc(wr_ptr_r) : wr_ptr_r;
    rd_ptr_nxt = pop  ? ptr_inc(rd_ptr_r) : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

>>> hw/rtl/atp_back.sv
// Back end: parse state machine, count accumulation and result register.
module atp_back import atp_pkg::*; #(
  parameter int COUNT_WIDTH = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       q_valid,
  input  atp_class_t q_data,
  output logic       pop,
  atp_out_if.source  out_ch
);

  typedef enum logic [2:0] {
    PH_LEAD,
    PH_KEYWORD,
    PH_KW_TAIL,
    PH_AFTER_MOD,
    PH_NUM,
    PH_NUM_SP,
    PH_AFTER_UNIT,
    PH_INVALID
  } phase_t;

  localparam int SW = COUNT_WIDTH + 4;

  phase_t                 phase_r, phase_nxt;
  logic [1:0]             kw_which_r, kw_which_nxt;
  logic [3:0]             kw_pos_r, kw_pos_nxt;
  logic [COUNT_WIDTH-1:0] acc_r, acc_nxt;
  logic [3:0]             set_r, set_nxt;   // y, m, w, d present
  logic [COUNT_WIDTH-1:0] yr_r, yr_nxt, mo_r, mo_nxt, wk_r, wk_nxt, dy_r, dy_nxt;
  logic [1:0]             mod_r, mod_nxt;

  logic                    out_valid_r, out_valid_nxt;
  logic [1:0]              out_status_r, out_status_nxt;
  logic [1:0]              out_mod_r, out_mod_nxt;
  logic signed [OUT_W-1:0] out_yr_r, out_yr_nxt, out_mo_r, out_mo_nxt;
  logic signed [OUT_W-1:0] out_wk_r, out_wk_nxt, out_dy_r, out_dy_nxt;

  logic                   is_end;
  logic [COUNT_WIDTH-1:0] add_base;
  logic [SW-1:0]          sum;
  logic [COUNT_WIDTH-1:0] acc_dig;
  logic [3:0]             kw_pos_inc;

  function automatic logic signed [OUT_W-1:0] cnt_out(logic v, logic [COUNT_WIDTH-1:0] x);
    return v ? OUT_W'(x) : '1;
  endfunction

  assign is_end = q_data.is_end;
  assign pop    = q_valid && (!is_end || !out_valid_r || out_ch.ready);

  // acc * 10 + digit, saturating; a fresh number starts from zero
  assign add_base   = (phase_r == PH_NUM) ? acc_r : '0;
  assign sum        = SW'({add_base, 3'b000}) + SW'({add_base, 1'b0}) + SW'(q_data.digit);
  assign acc_dig    = (|sum[SW-1:COUNT_WIDTH]) ? '1 : sum[COUNT_WIDTH-1:0];
  assign kw_pos_inc = kw_pos_r + 4'd1;

  always_comb begin
    phase_nxt    = phase_r;
    kw_which_nxt = kw_which_r;
    kw_pos_nxt   = kw_pos_r;
    acc_nxt      = acc_r;
    set_nxt      = set_r;
    yr_nxt       = yr_r;
    mo_nxt       = mo_r;
    wk_nxt       = wk_r;
    dy_nxt       = dy_r;
    mod_nxt      = mod_r;

    out_status_nxt = out_status_r;
    out_mod_nxt    = out_mod_r;
    out_yr_nxt     = out_yr_r;
    out_mo_nxt     = out_mo_r;
    out_wk_nxt     = out_wk_r;
    out_dy_nxt     = out_dy_r;
    out_valid_nxt  = out_ch.ready ? 1'b0 : out_valid_r;

    if (pop && is_end) begin
      out_valid_nxt  = 1'b1;
      out_status_nxt = ST_INVALID;
      out_mod_nxt    = mod_r;
      out_yr_nxt     = cnt_out(set_r[0], yr_r);
      out_mo_nxt     = cnt_out(set_r[1], mo_r);
      out_wk_nxt     = cnt_out(set_r[2], wk_r);
      out_dy_nxt     = cnt_out(set_r[3], dy_r);
      unique case (phase_r)
        PH_KW_TAIL: begin
          out_status_nxt = ST_KEYWORD;
          if (kw_which_r == KW_CHILD) begin
            out_mod_nxt = MOD_LT;
            out_yr_nxt  = OUT_W'(CHILD_YEARS);
          end else if (kw_which_r == KW_INFANT) begin
            out_mod_nxt = MOD_LT;
            out_yr_nxt  = OUT_W'(INFANT_YEARS);
          end else begin
            out_mod_nxt = MOD_NONE;
            out_yr_nxt  = OUT_W'(STILLBORN_YEARS);
          end
        end
        PH_NUM, PH_NUM_SP: begin
          // bare trailing number counts as years unless y, m or d was given
          if (!set_r[0] && !set_r[1] && !set_r[3]) begin
            out_status_nxt = ST_UNITS;
            out_yr_nxt     = cnt_out(1'b1, acc_r);
          end
        end
        PH_AFTER_UNIT: out_status_nxt = ST_UNITS;
        PH_LEAD, PH_KEYWORD, PH_AFTER_MOD, PH_INVALID: out_status_nxt = ST_INVALID;
      endcase
      phase_nxt    = PH_LEAD;
      kw_which_nxt = '0;
      kw_pos_nxt   = '0;
      acc_nxt      = '0;
      set_nxt      = '0;
      mod_nxt      = MOD_NONE;
    end else if (pop) begin
      unique case (phase_r)
        PH_LEAD: begin
          if (q_data.is_space) begin
            phase_nxt = PH_LEAD;
          end else if (q_data.letter == "C" || q_data.letter == "I" ||
                       q_data.letter == "S") begin
            kw_which_nxt = (q_data.letter == "C") ? KW_CHILD :
                           (q_data.letter == "I") ? KW_INFANT : KW_STILLBORN;
            kw_pos_nxt   = 4'd1;
            phase_nxt    = PH_KEYWORD;
          end else if (q_data.is_lt || q_data.is_gt) begin
            mod_nxt   = q_data.is_lt ? MOD_LT : MOD_GT;
            phase_nxt = PH_AFTER_MOD;
          end else if (q_data.is_digit) begin
            acc_nxt   = acc_dig;
            phase_nxt = PH_NUM;
          end else begin
            phase_nxt = PH_INVALID;
          end
        end
        PH_KEYWORD: begin
          if (q_data.letter == kw_char(kw_which_r, kw_pos_r)) begin
            kw_pos_nxt = kw_pos_inc;
            if (kw_pos_inc >= kw_len(kw_which_r)) begin
              phase_nxt = PH_KW_TAIL;
            end
          end else begin
            phase_nxt = PH_INVALID;
          end
        end
        PH_KW_TAIL: begin
          if (!q_data.is_space) phase_nxt = PH_INVALID;
        end
        PH_AFTER_MOD, PH_AFTER_UNIT: begin
          if (q_data.is_space) begin
            phase_nxt = phase_r;
          end else if (q_data.is_digit) begin
            acc_nxt   = acc_dig;
            phase_nxt = PH_NUM;
          end else begin
            phase_nxt = PH_INVALID;
          end
        end
        PH_NUM, PH_NUM_SP: begin
          if (q_data.is_digit && phase_r == PH_NUM) begin
            acc_nxt = acc_dig;
          end else if (q_data.is_space) begin
            phase_nxt = PH_NUM_SP;
          end else begin
            phase_nxt = PH_AFTER_UNIT;
            acc_nxt   = '0;
            case (q_data.unit)
              UNIT_Y: begin set_nxt[0] = 1'b1; yr_nxt = acc_r; end
              UNIT_M: begin set_nxt[1] = 1'b1; mo_nxt = acc_r; end
              UNIT_W: begin set_nxt[2] = 1'b1; wk_nxt = acc_r; end
              UNIT_D: begin set_nxt[3] = 1'b1; dy_nxt = acc_r; end
              default: begin
                acc_nxt   = acc_r;
                phase_nxt = PH_INVALID;
              end
            endcase
          end
        end
        PH_INVALID: phase_nxt = PH_INVALID;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_LEAD;
      kw_which_r   <= '0;
      kw_pos_r     <= '0;
      acc_r        <= '0;
      set_r        <= '0;
      mod_r        <= MOD_NONE;
      out_valid_r  <= 1'b0;
    end else begin
      phase_r      <= phase_nxt;
      kw_which_r   <= kw_which_nxt;
      kw_pos_r     <= kw_pos_nxt;
      acc_r        <= acc_nxt;
      set_r        <= set_nxt;
      mod_r        <= mod_nxt;
      out_valid_r  <= out_valid_nxt;
    end
    yr_r         <= yr_nxt;
    mo_r         <= mo_nxt;
    wk_r         <= wk_nxt;
    dy_r         <= dy_nxt;
    out_status_r <= out_status_nxt;
    out_mod_r    <= out_mod_nxt;
    out_yr_r     <= out_yr_nxt;
    out_mo_r     <= out_mo_nxt;
    out_wk_r     <= out_wk_nxt;
    out_dy_r     <= out_dy_nxt;
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.status   = out_status_r;
  assign out_ch.modifier = out_mod_r;
  assign out_ch.years    = out_yr_r;
  assign out_ch.months   = out_mo_r;
  assign out_ch.weeks    = out_wk_r;
  assign out_ch.days     = out_dy_r;

endmodule

>>> sim/age_text_parser_tb.sv
// Self-checking testbench for the age text parser: directed table, then random texts.
module age_text_parser_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import atp_pkg::*;

  localparam int COUNT_WIDTH = 16;
  localparam int COUNT_MAX   = (1 << COUNT_WIDTH) - 1;
  localparam int RAND_ITEMS  = 1150;
  localparam int N_DIR       = 9;
  localparam logic signed [OUT_W-1:0] ABSENT = '1;

  typedef enum logic [2:0] {
    SKIP_LEAD, IN_KEYWORD, KW_TRAIL, AFTER_MOD, IN_NUMBER, NUM_SPACE, AFTER_UNIT, BAD_TEXT
  } parse_ph_t;

  typedef struct packed {
    logic        [1:0]       status;
    logic        [1:0]       modifier;
    logic signed [OUT_W-1:0] years;
    logic signed [OUT_W-1:0] months;
    logic signed [OUT_W-1:0] weeks;
    logic signed [OUT_W-1:0] days;
  } age_res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  atp_in_if  in_ch ();
  atp_out_if out_ch ();

  age_text_parser #(.COUNT_WIDTH(COUNT_WIDTH)) i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #2 clk = ~clk;

  // parse state mirrored from the block
  parse_ph_t               phase;
  logic        [1:0]       kw_sel;
  int                      kw_pos;
  int                      num_acc;
  logic signed [OUT_W-1:0] yr, mo, wk, dy;
  logic        [1:0]       mod_sel;

  string kw_word [3] = '{"CHILD", "INFANT", "STILLBORN"};

  age_res_t     age_exp_q [$];
  logic   [7:0] txt_q [$];
  int           err_cnt = 0;
  int           items_sent = 0;
  bit           no_idle = 1'b0;

  // directed table; typed expectations only where obvious
  string    dir_text [N_DIR] = '{"", "child", "cHx", "99999y", "<", ">1y2M3w4d",
                                 " 5y\t6Y", "7\377", "STILLBORN"};
  bit       dir_zero_end [N_DIR] = '{0, 1, 0, 0, 0, 0, 1, 0, 0};
  bit       dir_typed [N_DIR]    = '{1, 1, 1, 1, 1, 0, 0, 1, 1};
  age_res_t dir_res [N_DIR] = '{
    '{ST_INVALID, MOD_NONE, ABSENT, ABSENT, ABSENT, ABSENT},
    '{ST_KEYWORD, MOD_LT,   17'sd8, ABSENT, ABSENT, ABSENT},
    '{ST_INVALID, MOD_NONE, ABSENT, ABSENT, ABSENT, ABSENT},
    '{ST_UNITS,   MOD_NONE, 17'sd65535, ABSENT, ABSENT, ABSENT},
    '{ST_INVALID, MOD_LT,   ABSENT, ABSENT, ABSENT, ABSENT},
    '0,
    '0,
    '{ST_INVALID, MOD_NONE, ABSENT, ABSENT, ABSENT, ABSENT},
    '{ST_KEYWORD, MOD_NONE, 17'sd0, ABSENT, ABSENT, ABSENT}
  };

  function automatic bit is_ws(logic [7:0] c);
    return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  function automatic bit is_num(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit is_letter(logic [7:0] c, logic [7:0] up);
    return c == up || c == up + 8'd32;
  endfunction

  function automatic void clear_text();
    phase   = SKIP_LEAD;
    kw_sel  = KW_CHILD;
    kw_pos  = 0;
    num_acc = 0;
    yr      = ABSENT;
    mo      = ABSENT;
    wk      = ABSENT;
    dy      = ABSENT;
    mod_sel = MOD_NONE;
  endfunction

  function automatic void add_digit(logic [7:0] c);
    num_acc = num_acc * 10 + int'(c - "0");
    if (num_acc > COUNT_MAX) num_acc = COUNT_MAX;
  endfunction

  function automatic bit take_unit(logic [7:0] c);
    logic signed [OUT_W-1:0] n;
    n = OUT_W'(num_acc);
    if (is_letter(c, "Y")) yr = n;
    else if (is_letter(c, "M")) mo = n;
    else if (is_letter(c, "W")) wk = n;
    else if (is_letter(c, "D")) dy = n;
    else return 1'b0;
    num_acc = 0;
    return 1'b1;
  endfunction

  function automatic void start_number(logic [7:0] c);
    num_acc = 0;
    add_digit(c);
    phase = IN_NUMBER;
  endfunction

  function automatic void parse_byte(logic [7:0] c);
    string word;
    case (phase)
      SKIP_LEAD: begin
        if (is_ws(c)) begin
        end else if (is_letter(c, "C") || is_letter(c, "I") || is_letter(c, "S")) begin
          kw_sel = is_letter(c, "C") ? KW_CHILD : (is_letter(c, "I") ? KW_INFANT : KW_STILLBORN);
          kw_pos = 1;
          phase  = IN_KEYWORD;
        end else if (c == "<" || c == ">") begin
          mod_sel = (c == "<") ? MOD_LT : MOD_GT;
          phase   = AFTER_MOD;
        end else if (is_num(c)) begin
          start_number(c);
        end else begin
          phase = BAD_TEXT;
        end
      end
      IN_KEYWORD: begin
        word = kw_word[kw_sel];
        if (kw_pos < word.len() && is_letter(c, word[kw_pos])) begin
          kw_pos++;
          if (kw_pos >= word.len()) phase = KW_TRAIL;
        end else begin
          phase = BAD_TEXT;
        end
      end
      KW_TRAIL: begin
        if (!is_ws(c)) phase = BAD_TEXT;
      end
      AFTER_MOD, AFTER_UNIT: begin
        if (is_ws(c)) begin
        end else if (is_num(c)) begin
          start_number(c);
        end else begin
          phase = BAD_TEXT;
        end
      end
      IN_NUMBER: begin
        if (is_num(c)) add_digit(c);
        else if (is_ws(c)) phase = NUM_SPACE;
        else phase = take_unit(c) ? AFTER_UNIT : BAD_TEXT;
      end
      NUM_SPACE: begin
        if (!is_ws(c)) phase = take_unit(c) ? AFTER_UNIT : BAD_TEXT;
      end
      default: phase = BAD_TEXT;
    endcase
  endfunction

  function automatic age_res_t close_text();
    age_res_t r;
    case (phase)
      KW_TRAIL: begin
        r.status = ST_KEYWORD;
        case (kw_sel)
          KW_CHILD:  begin mod_sel = MOD_LT;   yr = OUT_W'(CHILD_YEARS);     end
          KW_INFANT: begin mod_sel = MOD_LT;   yr = OUT_W'(INFANT_YEARS);    end
          default:   begin mod_sel = MOD_NONE; yr = OUT_W'(STILLBORN_YEARS); end
        endcase
      end
      IN_NUMBER, NUM_SPACE: begin
        // bare final number counts as years only if no y/m/d was given
        if (yr < 0 && mo < 0 && dy < 0) begin
          yr = OUT_W'(num_acc);
          r.status = ST_UNITS;
        end else begin
          r.status = ST_INVALID;
        end
      end
      AFTER_UNIT: r.status = ST_UNITS;
      default:    r.status = ST_INVALID;
    endcase
    r.modifier = mod_sel;
    r.years    = yr;
    r.months   = mo;
    r.weeks    = wk;
    r.days     = dy;
    clear_text();
    return r;
  endfunction

  // --- stimulus helpers ---
  function automatic void add_space();
    int k;
    k = $urandom_range(5);
    txt_q.push_back(k == 5 ? 8'h20 : 8'h09 + 8'(k));
  endfunction

  function automatic void add_number();
    int    r;
    int    n;
    string s;
    r = $urandom_range(9);
    if (r < 6) n = $urandom_range(0, 99);
    else if (r < 9) n = $urandom_range(0, COUNT_MAX);
    else n = $urandom_range(COUNT_MAX + 1, 9999999);
    s = $sformatf("%0d", n);
    for (int i = 0; i < s.len(); i++) txt_q.push_back(s[i]);
  endfunction

  task automatic send_item(input logic [7:0] c, input logic eot, input bit typed,
                           input age_res_t typed_res);
    age_res_t r;
    while (!no_idle && $urandom_range(99) < 15) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.char_code   <= c;
    in_ch.end_of_text <= eot;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    if (eot || c == 8'h00) begin
      r = close_text();
      age_exp_q.push_back(typed ? typed_res : r);
    end else begin
      parse_byte(c);
    end
    items_sent++;
    no_idle = items_sent >= 400 && items_sent < 700;
    @(negedge clk);
  endtask

  // result sink: random backpressure
  always @(negedge clk) out_ch.ready <= no_idle || $urandom_range(99) >= 15;

  task automatic chk_field(input string name, input int e, input int a);
    if (e != a) begin
      $error("%s: expected %0d, actual %0d", name, e, a);
      err_cnt++;
    end
  endtask

  always @(posedge clk) begin : res_check
    age_res_t e;
    if (rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (age_exp_q.size() == 0) begin
        $error("result transaction with no expectation pending");
        err_cnt++;
      end else begin
        e = age_exp_q.pop_front();
        chk_field("status",   int'(e.status),   int'(out_ch.status));
        chk_field("modifier", int'(e.modifier), int'(out_ch.modifier));
        chk_field("years",    int'(e.years),    int'(out_ch.years));
        chk_field("months",   int'(e.months),   int'(out_ch.months));
        chk_field("weeks",    int'(e.weeks),    int'(out_ch.weeks));
        chk_field("days",     int'(e.days),     int'(out_ch.days));
      end
    end
  end

  initial begin
    #2_000_000;
    $display("== FAIL ==");
    $finish;
  end

  initial begin : main
    int    kind;
    int    n_units;
    string word;
    string units;
    units = "YMWDymwd";
    in_ch.valid       = 1'b0;
    in_ch.char_code   = 8'h00;
    in_ch.end_of_text = 1'b0;
    clear_text();
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (int r = 0; r < N_DIR; r++) begin
      for (int i = 0; i < dir_text[r].len(); i++) send_item(dir_text[r][i], 1'b0, 1'b0, '0);
      if (dir_zero_end[r]) send_item(8'h00, 1'b0, dir_typed[r], dir_res[r]);
      else send_item(8'hA5, 1'b1, dir_typed[r], dir_res[r]);
    end

    items_sent = 0;
    while (items_sent < RAND_ITEMS) begin
      txt_q.delete();
      kind = $urandom_range(99);
      if ($urandom_range(3) == 0) repeat ($urandom_range(1, 2)) add_space();
      if (kind < 25) begin
        word = kw_word[$urandom_range(2)];
        for (int i = 0; i < word.len(); i++)
          txt_q.push_back(word[i] | ($urandom_range(1) ? 8'h20 : 8'h00));
        repeat ($urandom_range(0, 2)) add_space();
        // cut short some keywords
        if ($urandom_range(7) == 0) repeat ($urandom_range(1, 3)) void'(txt_q.pop_back());
      end else if (kind < 85) begin
        if ($urandom_range(2) == 0) begin
          txt_q.push_back($urandom_range(1) ? "<" : ">");
          repeat ($urandom_range(0, 1)) add_space();
        end
        n_units = $urandom_range(0, 4);
        repeat (n_units) begin
          add_number();
          if ($urandom_range(3) == 0) add_space();
          txt_q.push_back(units[$urandom_range(7)]);
          if ($urandom_range(3) == 0) add_space();
        end
        if (n_units == 0 || $urandom_range(3) == 0) add_number();
        if ($urandom_range(3) == 0) add_space();
      end else begin
        repeat ($urandom_range(0, 6)) txt_q.push_back(8'($urandom_range(255)));
      end
      // corrupt one byte of some well-formed texts
      if (kind < 85 && txt_q.size() > 0 && $urandom_range(6) == 0)
        txt_q[$urandom_range(txt_q.size() - 1)] = 8'($urandom_range(255));
      foreach (txt_q[i]) send_item(txt_q[i], 1'b0, 1'b0, '0);
      if ($urandom_range(3) == 0) send_item(8'h00, 1'b0, 1'b0, '0);
      else send_item(8'($urandom_range(255)), 1'b1, 1'b0, '0);
    end
    in_ch.valid <= 1'b0;

    while (age_exp_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (err_cnt == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

>>> filelist.f
hw/rtl/atp_pkg.sv
hw/rtl/atp_in_if.sv
hw/rtl/atp_out_if.sv
hw/rtl/atp_front.sv
hw/rtl/atp_queue.sv
hw/rtl/atp_back.sv
hw/rtl/age_text_parser.sv
sim/age_text_parser_tb.sv
